### rtl/core/bpg_pkg.sv
// ----------------------------------------------------------------------------
// Blink pattern generator package
// Register map, port widths and fixed sizes shared by the sample interface and core.
// ----------------------------------------------------------------------------
package bpg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes
  localparam cfg_idx_t REG_PERIOD      = 3'd0;
  localparam cfg_idx_t REG_THRESHOLD_0 = 3'd1;
  localparam cfg_idx_t REG_THRESHOLD_1 = 3'd2;
  localparam cfg_idx_t REG_THRESHOLD_2 = 3'd3;
  localparam cfg_idx_t REG_THRESHOLD_3 = 3'd4;
  localparam cfg_idx_t REG_LEVEL_BITS  = 3'd5;

  // Number of pattern entries that have a threshold and a level register.
  localparam int CFG_ENTRIES = 4;

  // Field widths
  localparam int TICK_W  = 32;          // period, thresholds, counter field
  localparam int PHASE_W = TICK_W + 1;  // phase count carries one extra bit

  typedef logic [TICK_W-1:0]      tick_t;
  typedef logic [PHASE_W-1:0]     phase_t;
  typedef logic [CFG_ENTRIES-1:0] level_t;

  localparam tick_t PERIOD_RESET = 32'd200000000;

endpackage

### rtl/core/bpg_sample_if.sv
// ----------------------------------------------------------------------------
// Blink pattern generator sample channel
// Valid/ready channel carrying one counter sample or restart per beat.
// ----------------------------------------------------------------------------
interface bpg_sample_if
  import bpg_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  mode;
  tick_t counter_value;

  modport source (output valid, output mode, output counter_value, input ready);
  modport sink   (input valid, input mode, input counter_value, output ready);
endinterface

### rtl/core/bpg_result_if.sv
// ----------------------------------------------------------------------------
// Blink pattern generator result channel
// Valid/ready channel carrying the LED level and wrap pulse per beat.
// ----------------------------------------------------------------------------
interface bpg_result_if;
  logic valid;
  logic ready;
  logic led_on;
  logic period_wrap;

  modport source (output valid, output led_on, output period_wrap, input ready);
  modport sink   (input valid, input led_on, input period_wrap, output ready);
endinterface

### rtl/core/blink_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// Blink pattern generator unit
// Steps an LED blink pattern from free-running counter samples.
// ----------------------------------------------------------------------------
// Usage. Each beat on the sample channel carries either a counter reading
// (mode 0) or a restart (mode 1). Every sample beat produces exactly one beat
// on the result channel, in order, with the LED level and the wrap pulse.
// The period, the four entry thresholds and the level bits must be written on the
// plain configuration port only while the unit is idle; the unit does not enforce it.
// Timing. A beat is taken into an input register, then the phase, cursor and
// output are computed in one pass into the result register. One beat per cycle
// is sustained while the receiver keeps ready high.
// Reset clears the phase, the cursor and the latched counter, loads the
// period with 200000000 ticks and clears thresholds and level bits. Both
// stages start empty.
// Stall. When the receiver holds ready low, the result register keeps its
// beat and the input register may still take one more beat; further sample
// beats are refused until the result drains.
// ----------------------------------------------------------------------------
module blink_pattern_generator_unit
  import bpg_pkg::*;
#(
  parameter int PATTERN_LEN   = 4,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  bpg_sample_if.sink     sample,
  bpg_result_if.source   result,
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_index,
  input  cfg_data_t      cfg_data
);

  // The counter field is 32 bits wide; a narrower counter wraps earlier.
  localparam int CNT_W = (COUNTER_WIDTH < TICK_W) ? COUNTER_WIDTH : TICK_W;
  localparam int CUR_W = $clog2(PATTERN_LEN);
  localparam logic [CUR_W-1:0] LAST_ENTRY = CUR_W'(PATTERN_LEN - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  tick_t  period_ticks;
  tick_t  threshold [CFG_ENTRIES];
  level_t level_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_RESET;
      for (int i = 0; i < CFG_ENTRIES; i++) threshold[i] <= '0;
      level_bits   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD:      period_ticks <= cfg_data;
        REG_THRESHOLD_0: threshold[0] <= cfg_data;
        REG_THRESHOLD_1: threshold[1] <= cfg_data;
        REG_THRESHOLD_2: threshold[2] <= cfg_data;
        REG_THRESHOLD_3: threshold[3] <= cfg_data;
        REG_LEVEL_BITS:  level_bits   <= cfg_data[CFG_ENTRIES-1:0];
        default: ;  // writes to unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register followed by the result register
  // --------------------------------------------------------------------------
  logic   s_valid;
  logic   s_mode;
  tick_t  s_count;
  logic   advance;

  assign advance      = !result.valid || result.ready;
  assign sample.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.ready) begin
      s_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s_mode  <= sample.mode;
      s_count <= sample.counter_value;
    end
  end

  // --------------------------------------------------------------------------
  // Pattern state and the single-pass step
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] last_counter;
  phase_t           phase_ticks;
  logic [CUR_W-1:0] entry_cursor;

  logic [CNT_W-1:0] cnt_now;
  logic [CNT_W-1:0] delta;
  tick_t            delta_ext;
  tick_t            delta_clamped;
  phase_t           phase_sum;
  tick_t            thr_sel;
  logic             step_cursor;
  logic [CUR_W-1:0] cursor_stepped;
  logic             led_c;
  logic             wrap_c;

  logic [CNT_W-1:0] last_counter_next;
  phase_t           phase_ticks_next;
  logic [CUR_W-1:0] entry_cursor_next;

  assign cnt_now       = s_count[CNT_W-1:0];
  assign delta         = cnt_now - last_counter;
  assign delta_ext     = TICK_W'(delta);
  assign delta_clamped = (delta_ext > period_ticks) ? period_ticks : delta_ext;
  assign phase_sum     = phase_ticks + PHASE_W'(delta_clamped);

  // Entries beyond the register set have threshold zero.
  always_comb begin
    thr_sel = '0;
    for (int i = 0; i < CFG_ENTRIES; i++) begin
      if (32'(entry_cursor) == 32'(i)) thr_sel = threshold[i];
    end
  end

  // The cursor moves at most one entry and stops at the last one.
  assign step_cursor    = (phase_sum > PHASE_W'(thr_sel)) && (entry_cursor < LAST_ENTRY);
  assign cursor_stepped = step_cursor ? entry_cursor + CUR_W'(1) : entry_cursor;

  // Level is taken from the entry reached before any wrap; unregistered
  // entries are dark.
  always_comb begin
    led_c = 1'b0;
    for (int i = 0; i < CFG_ENTRIES; i++) begin
      if (32'(cursor_stepped) == 32'(i)) led_c = level_bits[i];
    end
  end

  assign wrap_c = (phase_sum >= PHASE_W'(period_ticks));

  always_comb begin
    last_counter_next = cnt_now;
    if (s_mode) begin
      phase_ticks_next  = '0;
      entry_cursor_next = '0;
    end else if (wrap_c) begin
      phase_ticks_next  = phase_sum - PHASE_W'(period_ticks);
      entry_cursor_next = '0;
    end else begin
      phase_ticks_next  = phase_sum;
      entry_cursor_next = cursor_stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_counter <= '0;
      phase_ticks  <= '0;
      entry_cursor <= '0;
    end else if (advance && s_valid) begin
      last_counter <= last_counter_next;
      phase_ticks  <= phase_ticks_next;
      entry_cursor <= entry_cursor_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_valid) begin
      result.led_on      <= !s_mode && led_c;
      result.period_wrap <= !s_mode && wrap_c;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cursor_in_range : assert property (@(posedge clk) disable iff (rst)
    entry_cursor <= LAST_ENTRY)
    else $error("pattern cursor ran past the last entry");

  a_restart_dark : assert property (@(posedge clk) disable iff (rst)
    advance && s_valid && s_mode |=> !result.led_on && !result.period_wrap
      && phase_ticks == '0 && entry_cursor == '0)
    else $error("restart beat did not give a dark result and cleared state");

  a_wrap_resets_cursor : assert property (@(posedge clk) disable iff (rst)
    advance && s_valid && !s_mode && wrap_c |=> entry_cursor == '0 && result.period_wrap)
    else $error("wrap did not return the cursor to the first entry");

  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample channel refused a beat with the result register empty");

endmodule

### bench/blink_pattern_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Blink pattern generator unit testbench
// Feeds counter samples and restarts into the unit while both channels stall
// at random, tracks the phase, cursor and registers alongside it, and checks
// each LED beat against the tracked pattern.
// ----------------------------------------------------------------------------
module blink_pattern_generator_unit_tb;
  import bpg_pkg::*;

  localparam int       PATTERN_LEN   = 4;
  localparam int       LAST_ENTRY    = PATTERN_LEN - 1;
  localparam int       CYCLE_LIMIT   = 400000;
  localparam int       RANDOM_PHASES = 10;
  localparam int       PHASE_BEATS   = 115;
  localparam logic     MODE_SAMPLE   = 1'b0;
  localparam logic     MODE_RESTART  = 1'b1;
  // Indexes that the register map leaves unused; writes to them are dropped.
  localparam cfg_idx_t REG_SPARE_6   = 3'd6;
  localparam cfg_idx_t REG_SPARE_7   = 3'd7;

  typedef struct packed {
    logic led_on;
    logic period_wrap;
  } led_beat_t;

  // Tracks the pattern state beat by beat and holds the LED beats that the
  // unit still owes, oldest first.
  class led_pattern_scoreboard;
    tick_t     period;
    tick_t     thresholds [CFG_ENTRIES];
    level_t    levels;
    tick_t     prev_count;
    phase_t    phase;
    int        cursor;
    led_beat_t expected_leds [$];
    int        errors;

    function new();
      period = PERIOD_RESET;
      foreach (thresholds[i]) thresholds[i] = '0;
      levels     = '0;
      prev_count = '0;
      phase      = '0;
      cursor     = 0;
      errors     = 0;
    endfunction

    function void set_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_PERIOD:      period        = data;
        REG_THRESHOLD_0: thresholds[0] = data;
        REG_THRESHOLD_1: thresholds[1] = data;
        REG_THRESHOLD_2: thresholds[2] = data;
        REG_THRESHOLD_3: thresholds[3] = data;
        REG_LEVEL_BITS:  levels        = data[CFG_ENTRIES-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic mode, tick_t count);
      tick_t     delta;
      tick_t     limit;
      phase_t    next_phase;
      int        cur;
      led_beat_t beat;
      if (mode == MODE_RESTART) begin
        phase      = '0;
        cursor     = 0;
        prev_count = count;
        beat       = '0;
      end else begin
        // Elapsed ticks wrap with the counter and never exceed one period.
        delta = count - prev_count;
        if (delta > period) delta = period;
        prev_count = count;
        next_phase = phase + PHASE_W'(delta);
        cur   = (cursor > LAST_ENTRY) ? LAST_ENTRY : cursor;
        limit = (cur < CFG_ENTRIES) ? thresholds[cur] : '0;
        if (next_phase > PHASE_W'(limit) && cur < LAST_ENTRY) cur++;
        beat.led_on      = (cur < CFG_ENTRIES) ? levels[cur] : 1'b0;
        beat.period_wrap = 1'b0;
        if (next_phase >= PHASE_W'(period)) begin
          next_phase       = next_phase - PHASE_W'(period);
          cur              = 0;
          beat.period_wrap = 1'b1;
        end
        phase  = next_phase;
        cursor = cur;
      end
      expected_leds.push_back(beat);
    endfunction

    function void fail(string msg);
      errors++;
      $display("%s", msg);
    endfunction

    function void check_level(logic led_on, logic period_wrap);
      led_beat_t want;
      if (expected_leds.size() == 0) begin
        fail($sformatf("[%0t] unexpected result beat: expected none, actual led_on %0b wrap %0b",
                       $time, led_on, period_wrap));
        return;
      end
      want = expected_leds.pop_front();
      if (want.led_on !== led_on)
        fail($sformatf("[%0t] led_on mismatch: expected %0b, actual %0b",
                       $time, want.led_on, led_on));
      if (want.period_wrap !== period_wrap)
        fail($sformatf("[%0t] period_wrap mismatch: expected %0b, actual %0b",
                       $time, want.period_wrap, period_wrap));
    endfunction

    function void close_out();
      if (expected_leds.size() != 0)
        fail($sformatf("[%0t] missing result beats: expected %0d more, actual 0",
                       $time, expected_leds.size()));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  bpg_sample_if sample_ch ();
  bpg_result_if result_ch ();

  // The free-running counter that the samples are read from.
  tick_t tick_now   = '0;
  // While calm is set, neither side inserts gaps, so the unit runs flat out.
  bit    calm       = 1'b0;
  int    stall_left = 0;

  led_pattern_scoreboard sb = new();

  blink_pattern_generator_unit #(
    .PATTERN_LEN   (PATTERN_LEN),
    .COUNTER_WIDTH (TICK_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Gap lengths: most are zero or short, a few are long enough to let the
  // pipeline drain or back up completely.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Result side. The beat is checked at the edge where it is taken, using the
  // values from just before the edge; ready then follows a random stall plan.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_level(result_ch.led_on, result_ch.period_wrap);
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left      <= pick_gap();
    end
  end

  // Offers one beat, after an optional gap, and holds it until the unit takes
  // it. Valid stays high on exit so that a following beat with no gap goes out
  // back to back without valid dropping in between.
  task automatic send_beat(input logic mode, input tick_t count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.mode          <= mode;
    sample_ch.counter_value <= count;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(mode, count);
  endtask

  // Every sample beat yields one result beat, so an empty store of expected
  // beats means that the unit has nothing left in flight.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.expected_leds.size() != 0) @(posedge clk);
  endtask

  // The caller lowers the write enable after its last write.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic load_pattern(input tick_t per, input tick_t t0, input tick_t t1,
                              input tick_t t2, input tick_t t3, input level_t lv);
    write_reg(REG_PERIOD, per);
    write_reg(REG_THRESHOLD_0, t0);
    write_reg(REG_THRESHOLD_1, t1);
    write_reg(REG_THRESHOLD_2, t2);
    write_reg(REG_THRESHOLD_3, t3);
    write_reg(REG_LEVEL_BITS, cfg_data_t'(lv));
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed stepping of the counter, with the odd restart and the
  // odd jump to an arbitrary reading to shake every counter bit.
  task automatic run_random_phase(input int beats, input tick_t max_step);
    int roll;
    for (int n = 0; n < beats; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_beat(MODE_RESTART, tick_now);
      end else begin
        if (roll < 7) tick_now = $urandom();
        else tick_now = tick_now + $urandom_range(0, max_step);
        send_beat(MODE_SAMPLE, tick_now);
      end
    end
    drain();
  endtask

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("blink_pattern_generator_unit_tb: errors");
    $finish;
  end

  initial begin : stimulus
    tick_t  per;
    tick_t  t0;
    tick_t  t1;
    tick_t  t2;
    tick_t  t3;
    level_t lv;
    tick_t  step;

    cfg_we                  <= 1'b0;
    cfg_index               <= REG_PERIOD;
    cfg_data                <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.mode          <= MODE_SAMPLE;
    sample_ch.counter_value <= '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With the reset registers in place, a reading at the top
    // of the counter range is clamped to the period and wraps at once; then a
    // restart just below the top and a reading past zero check that elapsed
    // time is taken modulo the counter width.
    send_beat(MODE_SAMPLE, 32'hFFFF_FFFF);
    send_beat(MODE_RESTART, 32'hFFFF_FFF0);
    send_beat(MODE_SAMPLE, 32'h0000_0010);
    drain();

    // A short period with rising thresholds and the last threshold at its
    // maximum; the spare indexes are written with junk, which must change
    // nothing.
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h0000_0000);
    load_pattern(32'd100, 32'd10, 32'd20, 32'd30, 32'hFFFF_FFFF, 4'b0101);
    send_beat(MODE_RESTART, 32'd1000);
    send_beat(MODE_SAMPLE, 32'd1005);
    send_beat(MODE_SAMPLE, 32'd1015);
    send_beat(MODE_SAMPLE, 32'd1025);
    send_beat(MODE_SAMPLE, 32'd1035);
    send_beat(MODE_SAMPLE, 32'd1060);
    send_beat(MODE_SAMPLE, 32'd1090);
    send_beat(MODE_SAMPLE, 32'd1100);
    drain();

    // All thresholds at zero: the cursor climbs one entry per beat and must
    // saturate at the last entry rather than run off the table.
    load_pattern(32'd100, 32'd0, 32'd0, 32'd0, 32'd0, 4'b1010);
    send_beat(MODE_SAMPLE, 32'd1101);
    send_beat(MODE_SAMPLE, 32'd1102);
    send_beat(MODE_SAMPLE, 32'd1103);
    send_beat(MODE_SAMPLE, 32'd1104);
    send_beat(MODE_SAMPLE, 32'd1105);
    send_beat(MODE_SAMPLE, 32'd1190);
    drain();

    // The period is lowered below the phase; with the counter standing still
    // the phase comes down by one period per beat.
    write_reg(REG_PERIOD, 32'd20);
    cfg_we <= 1'b0;
    send_beat(MODE_SAMPLE, 32'd1190);
    send_beat(MODE_SAMPLE, 32'd1190);
    send_beat(MODE_SAMPLE, 32'd1190);
    drain();

    // A zero period adds nothing and wraps on every sample.
    write_reg(REG_PERIOD, 32'd0);
    cfg_we <= 1'b0;
    send_beat(MODE_SAMPLE, 32'd1300);
    send_beat(MODE_SAMPLE, 32'd5000);
    drain();

    // Random part, one register setting per phase. Half the phases use a short
    // period with rising thresholds and counter steps well below the period,
    // so that the cursor walks through every entry before each wrap.
    tick_now = 32'd5000;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == 2 || p == 6);
      lv   = level_t'($urandom_range(0, 15));
      case (p)
        3: begin
          // Zero period with arbitrary thresholds.
          per  = '0;
          t0   = $urandom();
          t1   = $urandom();
          t2   = $urandom();
          t3   = $urandom();
          step = 32'hFFFF_FFFF;
        end
        4: begin
          // Thresholds in no particular order.
          per  = $urandom_range(16, 2000);
          t0   = $urandom_range(0, per);
          t1   = $urandom_range(0, per);
          t2   = $urandom_range(0, per);
          t3   = $urandom_range(0, per);
          step = per / 6 + 1;
        end
        7: begin
          // Thresholds at their maximum: the cursor never leaves entry zero.
          per  = $urandom_range(16, 2000);
          t0   = 32'hFFFF_FFFF;
          t1   = 32'hFFFF_FFFF;
          t2   = 32'hFFFF_FFFF;
          t3   = 32'hFFFF_FFFF;
          step = per / 4 + 1;
        end
        8: begin
          // Largest period, thresholds spread over the whole range.
          per  = 32'hFFFF_FFFF;
          t0   = $urandom_range(0, 32'h3FFF_FFFF);
          t1   = t0 + $urandom_range(0, 32'h3FFF_FFFF);
          t2   = t1 + $urandom_range(0, 32'h3FFF_FFFF);
          t3   = 32'hFFFF_FFFF;
          step = 32'h2000_0000;
        end
        9: begin
          per  = $urandom_range(4, 64);
          t0   = '0;
          t1   = '0;
          t2   = '0;
          t3   = '0;
          lv   = 4'b1111;
          step = per / 3 + 1;
        end
        default: begin
          per  = $urandom_range(16, 2000);
          t0   = $urandom_range(0, per / 4);
          t1   = t0 + $urandom_range(0, per / 4);
          t2   = t1 + $urandom_range(0, per / 4);
          t3   = t2 + $urandom_range(0, per / 4);
          step = per / 6 + 1;
        end
      endcase
      load_pattern(per, t0, t1, t2, t3, lv);
      send_beat(MODE_RESTART, tick_now);
      run_random_phase(PHASE_BEATS, step);
    end
    calm = 1'b0;

    // Give a stray extra beat from the unit time to show up before closing.
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("blink_pattern_generator_unit_tb: clean");
    end else begin
      $display("blink_pattern_generator_unit_tb: errors");
    end
    $finish;
  end

endmodule
